@@ rtl/json_string_unescape_utf8_defines.svh @@
// assertion macros for the json string unescaper
// used by the top level only, no other dependencies
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

`ifndef SYNTH
`define JSU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsu check failed: implication");
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsu check failed: next cycle");
`else
`define JSU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/jsu_pkg.sv @@
// types, codes and helper functions of the json string unescaper
// no dependencies
package jsu_pkg;

   typedef enum logic [6:0] {
      PH_IDLE = 7'b0000001,
      PH_STR  = 7'b0000010,
      PH_ESC  = 7'b0000100,
      PH_HEXA = 7'b0001000,
      PH_BSL  = 7'b0010000,
      PH_UCH  = 7'b0100000,
      PH_HEXB = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_ERR   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_DELIM = 3'd0,
      ERR_CTRL  = 3'd1,
      ERR_ESC   = 3'd2,
      ERR_HEX   = 3'd3,
      ERR_SURR  = 3'd4,
      ERR_NUL   = 3'd5,
      ERR_TRUNC = 3'd6
   } err_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      err_type    fault;
      logic       last;
   } rsp_type;

   // up to four results caused by one request
   typedef struct packed {
      logic [3:0][7:0] bytes;
      kind_type        kind;
      err_type         code;
      logic [1:0]      last_idx;
   } group_type;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSL   = 8'h5c;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_N     = 8'h6e;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_FF    = 8'h0c;

   localparam logic [15:0] HI_SURR_MIN = 16'hd800;
   localparam logic [15:0] HI_SURR_MAX = 16'hdbff;
   localparam logic [15:0] LO_SURR_MIN = 16'hdc00;
   localparam logic [15:0] LO_SURR_MAX = 16'hdfff;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;

   function automatic group_type make_event(input kind_type kind, input err_type code);
      group_type g;
      g          = '0;
      g.kind     = kind;
      g.code     = code;
      g.last_idx = 2'd0;
      return g;
   endfunction

   function automatic group_type make_data(input logic [7:0] value);
      group_type g;
      g          = make_event(KIND_DATA, ERR_DELIM);
      g.bytes[0] = value;
      return g;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic group_type utf8_encode(input logic [20:0] cp);
      group_type g;
      g = make_event(KIND_DATA, ERR_DELIM);
      if (cp < 21'h80) begin
         g.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         g.bytes[0] = 8'hc0 | {3'b000, cp[10:6]};
         g.bytes[1] = {2'b10, cp[5:0]};
         g.last_idx = 2'd1;
      end else if (cp < SUPP_BASE) begin
         g.bytes[0] = 8'he0 | {4'b0000, cp[15:12]};
         g.bytes[1] = {2'b10, cp[11:6]};
         g.bytes[2] = {2'b10, cp[5:0]};
         g.last_idx = 2'd2;
      end else begin
         g.bytes[0] = 8'hf0 | {5'b00000, cp[20:18]};
         g.bytes[1] = {2'b10, cp[17:12]};
         g.bytes[2] = {2'b10, cp[11:6]};
         g.bytes[3] = {2'b10, cp[5:0]};
         g.last_idx = 2'd3;
      end
      return g;
   endfunction

endpackage

@@ rtl/jsu_decode.sv @@
// parser state and escape decoding, one request per cycle while fire is high
// depends on jsu_pkg
module jsu_decode
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      fire,
   input  req_type   req,
   output logic      grp_push,
   output group_type grp
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  dc_ff, dc_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  hsb_ff, hsb_in;

   logic [7:0]  c;
   logic [4:0]  hv;
   logic [15:0] acc_next;
   logic [20:0] cp_pair;
   logic        has;
   logic        err_hit;
   err_type     err_code;
   logic        emit_hit;
   logic [20:0] emit_cp;

   assign c        = req.in_byte;
   assign hv       = hex_value(c);
   assign acc_next = {acc_ff[11:0], hv[3:0]};
   assign cp_pair  = SUPP_BASE + {1'b0, hsb_ff, acc_next[9:0]};

   always_comb begin
      phase_in = phase_ff;
      dc_in    = dc_ff;
      acc_in   = acc_ff;
      hsb_in   = hsb_ff;
      has      = 1'b0;
      grp      = make_event(KIND_DATA, ERR_DELIM);
      err_hit  = 1'b0;
      err_code = ERR_DELIM;
      emit_hit = 1'b0;
      emit_cp  = '0;

      if (req.stream_end) begin
         err_hit  = 1'b1;
         err_code = ERR_TRUNC;
      end else begin
         unique case (phase_ff) inside
            PH_STR: begin
               if (c == CHAR_QUOTE) begin
                  has      = 1'b1;
                  grp      = make_event(KIND_CLOSE, ERR_DELIM);
                  phase_in = PH_IDLE;
                  dc_in    = '0;
                  acc_in   = '0;
                  hsb_in   = '0;
               end else if (c < 8'h20) begin
                  err_hit  = 1'b1;
                  err_code = ERR_CTRL;
               end else if (c == CHAR_BSL) begin
                  phase_in = PH_ESC;
               end else begin
                  has = 1'b1;
                  grp = make_data(c);
               end
            end
            PH_ESC: begin
               phase_in = PH_STR;
               has      = 1'b1;
               case (c) inside
                  CHAR_QUOTE, CHAR_BSL, CHAR_SLASH: grp = make_data(c);
                  CHAR_B: grp = make_data(CHAR_BS);
                  CHAR_F: grp = make_data(CHAR_FF);
                  CHAR_N: grp = make_data(CHAR_LF);
                  CHAR_R: grp = make_data(CHAR_CR);
                  CHAR_T: grp = make_data(CHAR_TAB);
                  CHAR_U: begin
                     has      = 1'b0;
                     phase_in = PH_HEXA;
                     dc_in    = '0;
                     acc_in   = '0;
                  end
                  default: begin
                     has      = 1'b0;
                     err_hit  = 1'b1;
                     err_code = ERR_ESC;
                  end
               endcase
            end
            PH_HEXA, PH_HEXB: begin
               if (!hv[4]) begin
                  err_hit  = 1'b1;
                  err_code = ERR_HEX;
               end else if (dc_ff != 2'd3) begin
                  acc_in = acc_next;
                  dc_in  = dc_ff + 2'd1;
               end else if (phase_ff == PH_HEXA) begin
                  if (acc_next >= HI_SURR_MIN && acc_next <= HI_SURR_MAX) begin
                     hsb_in   = acc_next[9:0];
                     acc_in   = '0;
                     dc_in    = '0;
                     phase_in = PH_BSL;
                  end else if (acc_next >= LO_SURR_MIN && acc_next <= LO_SURR_MAX) begin
                     err_hit  = 1'b1;
                     err_code = ERR_SURR;
                  end else if (acc_next == 16'h0000) begin
                     err_hit  = 1'b1;
                     err_code = ERR_NUL;
                  end else begin
                     emit_hit = 1'b1;
                     emit_cp  = {5'b00000, acc_next};
                  end
               end else begin
                  if (acc_next < LO_SURR_MIN || acc_next > LO_SURR_MAX) begin
                     err_hit  = 1'b1;
                     err_code = ERR_SURR;
                  end else begin
                     emit_hit = 1'b1;
                     emit_cp  = cp_pair;
                  end
               end
            end
            PH_BSL: begin
               if (c != CHAR_BSL) begin
                  err_hit  = 1'b1;
                  err_code = ERR_SURR;
               end else begin
                  phase_in = PH_UCH;
               end
            end
            PH_UCH: begin
               if (c != CHAR_U) begin
                  err_hit  = 1'b1;
                  err_code = ERR_SURR;
               end else begin
                  phase_in = PH_HEXB;
                  dc_in    = '0;
                  acc_in   = '0;
               end
            end
            default: begin
               // idle, and any unused phase code
               if (c == CHAR_SPACE || c == CHAR_LF || c == CHAR_CR || c == CHAR_TAB) begin
                  phase_in = PH_IDLE;
               end else if (c == CHAR_QUOTE) begin
                  phase_in = PH_STR;
                  dc_in    = '0;
                  acc_in   = '0;
                  hsb_in   = '0;
               end else begin
                  err_hit  = 1'b1;
                  err_code = ERR_DELIM;
               end
            end
         endcase
      end

      if (emit_hit) begin
         has      = 1'b1;
         grp      = utf8_encode(emit_cp);
         phase_in = PH_STR;
         dc_in    = '0;
         acc_in   = '0;
         hsb_in   = '0;
      end

      if (err_hit) begin
         has      = 1'b1;
         grp      = make_event(KIND_ERR, err_code);
         phase_in = PH_IDLE;
         dc_in    = '0;
         acc_in   = '0;
         hsb_in   = '0;
      end
   end

   assign grp_push = fire & has;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         dc_ff    <= '0;
         acc_ff   <= '0;
         hsb_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         dc_ff    <= dc_in;
         acc_ff   <= acc_in;
         hsb_ff   <= hsb_in;
      end
   end

endmodule

@@ rtl/jsu_queue.sv @@
// result group queue and byte serialiser with output register
// depends on jsu_pkg
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_grp,
   output logic      full,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type        queue_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   group_type head;
   logic      load;
   logic      pop;
   logic      head_last;

   assign head      = queue_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign load      = (!rsp_valid_ff || rsp_ready) && (count_ff != '0);
   assign head_last = (idx_ff == head.last_idx);
   assign pop       = load && head_last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      if (load) begin
         idx_in = head_last ? 2'd0 : idx_ff + 2'd1;
      end

      rsp_data_in          = rsp_data_ff;
      rsp_data_in.out_byte = head.bytes[idx_ff];
      rsp_data_in.kind     = head.kind;
      rsp_data_in.fault    = head.code;
      rsp_data_in.last     = head_last;

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_grp;
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// throughput: one request per cycle while the group queue is not full; results
// leave one byte per cycle while rsp_ready is high, a surrogate pair giving four
// bytes, held in a QUEUE_DEPTH-entry group queue
// reset (synchronous, active high) returns the parser to idle and empties the queue
// top level: input register, decoder, result queue; depends on jsu_pkg
`include "json_string_unescape_utf8_defines.svh"
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff;
   logic      fire;
   logic      q_full;
   logic      grp_push;
   group_type grp;
   logic      rsp_event;

   assign fire      = in_valid_ff && !q_full;
   assign req_ready = !in_valid_ff || fire;
   assign rsp_event = rsp_valid && (rsp_data.kind != KIND_DATA);

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   jsu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req      (in_data_ff),
      .grp_push (grp_push),
      .grp      (grp)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_grp  (grp),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `JSU_ASSERT_IMPL(a_idle_ready, clock, reset, !in_valid_ff, req_ready)
   `JSU_ASSERT_IMPL(a_no_overwrite, clock, reset, in_valid_ff && q_full, !req_ready)
   `JSU_ASSERT_IMPL(a_event_last, clock, reset, rsp_event, rsp_data.last)
   `JSU_ASSERT_IMPL(a_event_zero, clock, reset, rsp_event, rsp_data.out_byte == 8'h00)
   `JSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

@@ tb/json_string_unescape_utf8_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the json string unescaper with utf-8 output
// directed table then random json strings, checked against an in-bench decoder
// depends on jsu_pkg and the json_string_unescape_utf8 top level
module json_string_unescape_utf8_test
   import jsu_pkg::*;
();

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_ITEMS   = 480;
   localparam int IDLE_PERCENT   = 7;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 40;
   localparam int N_DIRECTED     = 34;

   typedef struct {
      logic [7:0] in_byte;
      logic       stream_end;
      bit         fixed;
      kind_type   kind;
      err_type    code;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;

   // typed-in expectation travelling with the request
   bit      row_fixed = 1'b0;
   rsp_type row_rsp = '0;

   bit      calm = 1'b0;
   int      items_sent = 0;
   int      mismatches = 0;
   int      quiet_cycles = 0;

   rsp_type expected_q [$];
   rsp_type step_q [$];
   req_type chunk_q [$];

   // decoder state
   phase_type   parse_phase = PH_IDLE;
   logic [1:0]  digit_cnt = '0;
   logic [15:0] code_acc = '0;
   logic [9:0]  high_bits = '0;

   logic [7:0] esc_chars [8] = '{CHAR_QUOTE, CHAR_BSL, CHAR_SLASH, CHAR_B,
                                 CHAR_F, CHAR_N, CHAR_R, CHAR_T};
   logic [7:0] ws_chars [4] = '{CHAR_SPACE, CHAR_LF, CHAR_CR, CHAR_TAB};

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{8'h00,      1'b1, 1'b1, KIND_ERR,  ERR_TRUNC},
      '{8'h00,      1'b0, 1'b1, KIND_ERR,  ERR_DELIM},
      '{CHAR_QUOTE, 1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h00,      1'b0, 1'b1, KIND_ERR,  ERR_CTRL},
      '{CHAR_QUOTE, 1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'hff,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_BSL,   1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h71,      1'b0, 1'b1, KIND_ERR,  ERR_ESC},
      '{CHAR_QUOTE, 1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_BSL,   1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_U,     1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h30,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h30,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h30,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h30,      1'b0, 1'b1, KIND_ERR,  ERR_NUL},
      '{CHAR_QUOTE, 1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_BSL,   1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_U,     1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h44,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h43,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h30,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h30,      1'b0, 1'b1, KIND_ERR,  ERR_SURR},
      '{CHAR_QUOTE, 1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_BSL,   1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_U,     1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h64,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h38,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h30,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h30,      1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h78,      1'b0, 1'b1, KIND_ERR,  ERR_SURR},
      '{CHAR_QUOTE, 1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_BSL,   1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{CHAR_U,     1'b0, 1'b0, KIND_DATA, ERR_DELIM},
      '{8'h67,      1'b0, 1'b1, KIND_ERR,  ERR_HEX}
   };

   json_string_unescape_utf8 u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void add_result(input logic [7:0] b, input kind_type k,
                                      input err_type e);
      rsp_type x;
      x.out_byte = b;
      x.kind     = k;
      x.fault    = e;
      x.last     = 1'b0;
      step_q     = {step_q, x};
   endfunction

   function automatic void back_to_idle();
      parse_phase = PH_IDLE;
      digit_cnt   = '0;
      code_acc    = '0;
      high_bits   = '0;
   endfunction

   function automatic void raise_error(input err_type e);
      back_to_idle();
      add_result(8'h00, KIND_ERR, e);
   endfunction

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   function automatic void emit_utf8(input logic [20:0] cp);
      if (cp < 21'h80) begin
         add_result(cp[7:0], KIND_DATA, ERR_DELIM);
      end else if (cp < 21'h800) begin
         add_result({3'b110, cp[10:6]}, KIND_DATA, ERR_DELIM);
         add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_DELIM);
      end else if (cp < SUPP_BASE) begin
         add_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_DELIM);
         add_result({2'b10, cp[11:6]}, KIND_DATA, ERR_DELIM);
         add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_DELIM);
      end else begin
         add_result({5'b11110, cp[20:18]}, KIND_DATA, ERR_DELIM);
         add_result({2'b10, cp[17:12]}, KIND_DATA, ERR_DELIM);
         add_result({2'b10, cp[11:6]}, KIND_DATA, ERR_DELIM);
         add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_DELIM);
      end
      back_to_idle();
      parse_phase = PH_STR;
   endfunction

   // decodes one request into step_q
   function automatic void unescape_byte(input req_type r);
      logic [7:0]  c;
      int          v;
      logic [20:0] cp;
      c = r.in_byte;
      step_q.delete();
      if (r.stream_end) begin
         raise_error(ERR_TRUNC);
      end else begin
         case (parse_phase) inside
            PH_STR: begin
               if (c == CHAR_QUOTE) begin
                  back_to_idle();
                  add_result(8'h00, KIND_CLOSE, ERR_DELIM);
               end else if (c < 8'h20) begin
                  raise_error(ERR_CTRL);
               end else if (c == CHAR_BSL) begin
                  parse_phase = PH_ESC;
               end else begin
                  add_result(c, KIND_DATA, ERR_DELIM);
               end
            end
            PH_ESC: begin
               parse_phase = PH_STR;
               case (c) inside
                  CHAR_QUOTE, CHAR_BSL, CHAR_SLASH: add_result(c, KIND_DATA, ERR_DELIM);
                  CHAR_B: add_result(CHAR_BS, KIND_DATA, ERR_DELIM);
                  CHAR_F: add_result(CHAR_FF, KIND_DATA, ERR_DELIM);
                  CHAR_N: add_result(CHAR_LF, KIND_DATA, ERR_DELIM);
                  CHAR_R: add_result(CHAR_CR, KIND_DATA, ERR_DELIM);
                  CHAR_T: add_result(CHAR_TAB, KIND_DATA, ERR_DELIM);
                  CHAR_U: begin
                     parse_phase = PH_HEXA;
                     digit_cnt   = '0;
                     code_acc    = '0;
                  end
                  default: raise_error(ERR_ESC);
               endcase
            end
            PH_HEXA, PH_HEXB: begin
               v = hex_nibble(c);
               if (v < 0) begin
                  raise_error(ERR_HEX);
               end else begin
                  code_acc = {code_acc[11:0], v[3:0]};
                  if (digit_cnt < 2'd3) begin
                     digit_cnt = digit_cnt + 2'd1;
                  end else begin
                     digit_cnt = '0;
                     if (parse_phase == PH_HEXA) begin
                        if (code_acc >= HI_SURR_MIN && code_acc <= HI_SURR_MAX) begin
                           high_bits   = code_acc[9:0];
                           code_acc    = '0;
                           parse_phase = PH_BSL;
                        end else if (code_acc >= LO_SURR_MIN && code_acc <= LO_SURR_MAX) begin
                           raise_error(ERR_SURR);
                        end else if (code_acc == 16'h0000) begin
                           raise_error(ERR_NUL);
                        end else begin
                           emit_utf8({5'b00000, code_acc});
                        end
                     end else if (code_acc < LO_SURR_MIN || code_acc > LO_SURR_MAX) begin
                        raise_error(ERR_SURR);
                     end else begin
                        cp = SUPP_BASE + {1'b0, high_bits, 10'd0}
                             + {5'b00000, code_acc - LO_SURR_MIN};
                        emit_utf8(cp);
                     end
                  end
               end
            end
            PH_BSL: begin
               if (c != CHAR_BSL) raise_error(ERR_SURR);
               else parse_phase = PH_UCH;
            end
            PH_UCH: begin
               if (c != CHAR_U) begin
                  raise_error(ERR_SURR);
               end else begin
                  parse_phase = PH_HEXB;
                  digit_cnt   = '0;
                  code_acc    = '0;
               end
            end
            default: begin
               if (c == CHAR_SPACE || c == CHAR_LF || c == CHAR_CR || c == CHAR_TAB) begin
                  parse_phase = PH_IDLE;
               end else if (c == CHAR_QUOTE) begin
                  back_to_idle();
                  parse_phase = PH_STR;
               end else begin
                  raise_error(ERR_DELIM);
               end
            end
         endcase
      end
      if (step_q.size() > 0) step_q[$].last = 1'b1;
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      req_type r;
      r.in_byte    = b;
      r.stream_end = 1'b0;
      chunk_q      = {chunk_q, r};
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + v;
      return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
   endfunction

   function automatic void put_unicode(input logic [15:0] v);
      put_byte(CHAR_BSL);
      put_byte(CHAR_U);
      for (int i = 3; i >= 0; i--) put_byte(hex_ascii(v[4*i +: 4]));
   endfunction

   function automatic logic [15:0] pick_bmp();
      logic [15:0] edges [8] = '{16'h0001, 16'h007f, 16'h0080, 16'h07ff,
                                 16'h0800, 16'hd7ff, 16'he000, 16'hffff};
      if ($urandom_range(15) == 0) return edges[3'($urandom_range(7))];
      case ($urandom_range(2))
         0: return 16'($urandom_range(16'h7f, 1));
         1: return 16'($urandom_range(16'h7ff, 16'h80));
         default: return 16'($urandom_range(1) ? $urandom_range(16'hd7ff, 16'h800)
                                               : $urandom_range(16'hffff, 16'he000));
      endcase
   endfunction

   // one json string, sometimes broken, or a burst of noise
   function automatic void build_text();
      logic [7:0]  b;
      logic [15:0] hi;
      logic [15:0] lo;
      int          pos;
      req_type     r;
      chunk_q.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(4, 1)) begin
            r.in_byte    = 8'($urandom_range(255));
            r.stream_end = ($urandom_range(7) == 0);
            chunk_q      = {chunk_q, r};
         end
         return;
      end
      repeat ($urandom_range(2)) put_byte(ws_chars[2'($urandom_range(3))]);
      put_byte(CHAR_QUOTE);
      repeat ($urandom_range(8, 1)) begin
         case ($urandom_range(9)) inside
            [0:3]: begin
               do b = 8'($urandom_range(8'hff, 8'h20)); while (b == CHAR_QUOTE || b == CHAR_BSL);
               put_byte(b);
            end
            [4:5]: begin
               put_byte(CHAR_BSL);
               put_byte(esc_chars[3'($urandom_range(7))]);
            end
            [6:8]: put_unicode(pick_bmp());
            default: begin
               if ($urandom_range(7) == 0) begin
                  hi = $urandom_range(1) ? HI_SURR_MIN : HI_SURR_MAX;
                  lo = $urandom_range(1) ? LO_SURR_MIN : LO_SURR_MAX;
               end else begin
                  hi = 16'($urandom_range(HI_SURR_MAX, HI_SURR_MIN));
                  lo = 16'($urandom_range(LO_SURR_MAX, LO_SURR_MIN));
               end
               put_unicode(hi);
               put_unicode(lo);
            end
         endcase
      end
      if ($urandom_range(19) != 0) put_byte(CHAR_QUOTE);
      if ($urandom_range(99) < 20) begin
         pos = $urandom_range(chunk_q.size() - 1);
         r = chunk_q[pos];
         r.in_byte = 8'($urandom_range(255));
         if ($urandom_range(3) == 0) r.stream_end = 1'b1;
         chunk_q[pos] = r;
      end
   endfunction

   task automatic send_req(input req_type r, input bit fixed, input rsp_type fixed_rsp);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      row_fixed <= fixed;
      row_rsp   <= fixed_rsp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      calm <= (items_sent >= 200 && items_sent < 320);
   endtask

   task automatic report_mismatch(input string what, input int want_v, input int got_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want_v, got_v);
      end
   endtask

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            unescape_byte(req_data);
            if (row_fixed) begin
               expected_q = {expected_q, row_rsp};
            end else begin
               expected_q = {expected_q, step_q};
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with nothing pending", 0, int'(rsp_data));
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.out_byte != want.out_byte)
                  report_mismatch("out_byte", want.out_byte, rsp_data.out_byte);
               if (rsp_data.kind != want.kind)
                  report_mismatch("kind", want.kind, rsp_data.kind);
               if (rsp_data.fault != want.fault)
                  report_mismatch("fault", want.fault, rsp_data.fault);
               if (rsp_data.last != want.last)
                  report_mismatch("last", want.last, rsp_data.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : run_stimulus
      req_type r;
      rsp_type f;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         r.in_byte    = directed_rows[i].in_byte;
         r.stream_end = directed_rows[i].stream_end;
         f            = '0;
         f.kind       = directed_rows[i].kind;
         f.fault      = directed_rows[i].code;
         f.last       = 1'b1;
         send_req(r, directed_rows[i].fixed, f);
      end
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         build_text();
         foreach (chunk_q[i]) send_req(chunk_q[i], 1'b0, '0);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_queue.sv
rtl/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_test.sv
